/* hw/rtl/status_led_blink_pattern_macros.svh */
// Assertion helpers for the status LED blink pattern block.
// Every macro expects i_clk and i_rst_n to be visible where it is used.
`ifndef STATUS_LED_BLINK_PATTERN_MACROS_SVH
`define STATUS_LED_BLINK_PATTERN_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define SLBP_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("slbp assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SLBP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("slbp assertion failed");

`else

`define SLBP_ASSERT_IMPL(label, ante, cons)
`define SLBP_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* hw/rtl/slbp_pkg.sv */
package slbp_pkg;

    // Field widths.
    localparam int OP_W     = 2;
    localparam int TIME_W   = 32;
    localparam int MODE_W   = 3;
    localparam int BLINK_W  = 7;
    localparam int STEP_W   = 8;
    localparam int DUR_W    = 16;
    localparam int CFG_N    = 8;
    localparam int CFG_IDX_W = 3;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_TICK       = 2'd0;
    localparam logic [OP_W-1:0] OP_SET_MODE   = 2'd1;
    localparam logic [OP_W-1:0] OP_SET_BLINKS = 2'd2;

    // Mode codes.
    localparam logic [MODE_W-1:0] MODE_OFF       = 3'd0;
    localparam logic [MODE_W-1:0] MODE_HEARTBEAT = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SLOW      = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FAULT     = 3'd3;
    localparam logic [MODE_W-1:0] MODE_ERROR     = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_HB_ON     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HB_OFF    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_ON   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_OFF  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FAULT_ON  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FAULT_GAP = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FAULT_PAUSE = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_ERR_PERIOD  = 3'd7;

    // Register values after reset, in index order.
    localparam logic [DUR_W-1:0] CFG_RESET [CFG_N] = '{
        16'd100, 16'd1900, 16'd500, 16'd2000, 16'd100, 16'd150, 16'd1500, 16'd200
    };

    // Phase durations as seen by the pattern logic.
    typedef struct packed {
        logic [DUR_W-1:0] hb_on;
        logic [DUR_W-1:0] hb_off;
        logic [DUR_W-1:0] slow_on;
        logic [DUR_W-1:0] slow_off;
        logic [DUR_W-1:0] fault_on;
        logic [DUR_W-1:0] fault_gap;
        logic [DUR_W-1:0] fault_pause;
        logic [DUR_W-1:0] err_period;
    } t_cfg;

    // One input beat.
    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [TIME_W-1:0]  now_ms;
        logic [MODE_W-1:0]  mode_code;
        logic [BLINK_W-1:0] blink_count;
    } t_item;

    // One result beat.
    typedef struct packed {
        logic              led_on;
        logic [STEP_W-1:0] phase_step;
    } t_result;

endpackage

/* hw/rtl/slbp_in_if.sv */
interface slbp_in_if;
    logic                           valid;
    logic                           ready;
    logic [slbp_pkg::OP_W-1:0]      op;
    logic [slbp_pkg::TIME_W-1:0]    now_ms;
    logic [slbp_pkg::MODE_W-1:0]    mode_code;
    logic [slbp_pkg::BLINK_W-1:0]   blink_count;

    modport source (output valid, output op, output now_ms, output mode_code,
                    output blink_count, input ready);
    modport sink   (input valid, input op, input now_ms, input mode_code,
                    input blink_count, output ready);
endinterface

/* hw/rtl/slbp_out_if.sv */
interface slbp_out_if;
    logic                          valid;
    logic                          ready;
    logic                          led_on;
    logic [slbp_pkg::STEP_W-1:0]   phase_step;

    modport source (output valid, output led_on, output phase_step, input ready);
    modport sink   (input valid, input led_on, input phase_step, output ready);
endinterface

/* hw/rtl/status_led_blink_pattern.sv */
// Status LED pattern generator. Each beat on i_req is a tick, a mode change
// or a fault blink count, stamped with a 32-bit millisecond time, and yields
// exactly one beat on o_rsp with the LED level and phase index after it.
// A beat is captured in an input register and its result is loaded into the
// output register once that register is empty or being taken; o_rsp.valid
// and the result come straight from that output register.
// The block sustains one beat per cycle while results are taken, bounded by
// the combinational pattern state update (one subtract, one compare, step
// update); a held result stalls the input only once both registers are full.
// Timing registers are written through i_cfg_we/i_cfg_idx/i_cfg_data and
// should only change while no beat is in flight.
`include "status_led_blink_pattern_macros.svh"

module status_led_blink_pattern (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    slbp_in_if.sink                         i_req,
    slbp_out_if.source                      o_rsp,
    input  logic                            i_cfg_we,
    input  logic [slbp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [slbp_pkg::DUR_W-1:0]      i_cfg_data
);
    import slbp_pkg::*;

    t_cfg    w_cfg;
    t_item   r_item;
    t_result r_res;
    t_result w_res;
    logic    r_in_valid,  n_in_valid;
    logic    r_out_valid, n_out_valid;
    logic    w_adv;
    logic    w_fire;
    logic    w_accept;

    slbp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    slbp_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_item  (r_item),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    // Flow control: the output register frees when empty or taken.
    assign w_adv       = !r_out_valid || o_rsp.ready;
    assign w_fire      = r_in_valid && w_adv;
    assign i_req.ready = !r_in_valid || w_adv;
    assign w_accept    = i_req.valid && i_req.ready;

    always_comb begin
        n_in_valid = r_in_valid;
        if (w_accept) begin
            n_in_valid = 1'b1;
        end else if (w_adv) begin
            n_in_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (w_fire) begin
            n_out_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
    end

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Input beat and result payload registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item.op          <= i_req.op;
            r_item.now_ms      <= i_req.now_ms;
            r_item.mode_code   <= i_req.mode_code;
            r_item.blink_count <= i_req.blink_count;
        end
        if (w_fire) begin
            r_res <= w_res;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.led_on     = r_res.led_on;
    assign o_rsp.phase_step = r_res.phase_step;

    `SLBP_ASSERT_IMPL(a_full_stall_blocks, r_in_valid && r_out_valid && !o_rsp.ready, !i_req.ready)
    `SLBP_ASSERT_NEXT(a_fire_gives_result, w_fire, r_out_valid)
    `SLBP_ASSERT_NEXT(a_accept_fills_input, w_accept, r_in_valid)

endmodule

/* hw/rtl/slbp_cfg.sv */
module slbp_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_we,
    input  logic [slbp_pkg::CFG_IDX_W-1:0]   i_idx,
    input  logic [slbp_pkg::DUR_W-1:0]       i_data,
    output slbp_pkg::t_cfg                   o_cfg
);
    import slbp_pkg::*;

    logic [DUR_W-1:0] r_regs [CFG_N];

    // Register file: reset to the default timing, one write per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs <= CFG_RESET;
        end else if (i_we) begin
            r_regs[i_idx] <= i_data;
        end
    end

    // Each register feeds its own duration field.
    assign o_cfg.hb_on       = r_regs[CFG_HB_ON];
    assign o_cfg.hb_off      = r_regs[CFG_HB_OFF];
    assign o_cfg.slow_on     = r_regs[CFG_SLOW_ON];
    assign o_cfg.slow_off    = r_regs[CFG_SLOW_OFF];
    assign o_cfg.fault_on    = r_regs[CFG_FAULT_ON];
    assign o_cfg.fault_gap   = r_regs[CFG_FAULT_GAP];
    assign o_cfg.fault_pause = r_regs[CFG_FAULT_PAUSE];
    assign o_cfg.err_period  = r_regs[CFG_ERR_PERIOD];

endmodule

/* hw/rtl/slbp_core.sv */
`include "status_led_blink_pattern_macros.svh"

module slbp_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  slbp_pkg::t_item   i_item,
    input  slbp_pkg::t_cfg    i_cfg,
    output slbp_pkg::t_result o_res
);
    import slbp_pkg::*;

    logic [MODE_W-1:0]  r_mode,   n_mode;
    logic [STEP_W-1:0]  r_step,   n_step;
    logic [TIME_W-1:0]  r_last,   n_last;
    logic               r_led,    n_led;
    logic [BLINK_W-1:0] r_blinks, n_blinks;

    logic [TIME_W-1:0]  w_elapsed;
    logic [DUR_W-1:0]   w_dur;
    logic               w_over;
    logic [STEP_W-1:0]  w_total;
    logic               w_last_phase;
    logic [STEP_W-1:0]  w_two_next;
    logic [STEP_W-1:0]  w_fault_next;

    // Time in the current phase, with modulo 2^32 wrap.
    assign w_elapsed = i_item.now_ms - r_last;

    // Fault pattern length and position.
    assign w_total      = {r_blinks, 1'b0};
    assign w_last_phase = (r_step == (w_total - 8'd1));

    // Duration of the current phase for the active mode.
    always_comb begin
        case (r_mode)
            MODE_HEARTBEAT: w_dur = r_step[0] ? i_cfg.hb_off : i_cfg.hb_on;
            MODE_SLOW:      w_dur = r_step[0] ? i_cfg.slow_off : i_cfg.slow_on;
            MODE_ERROR:     w_dur = i_cfg.err_period;
            MODE_FAULT: begin
                if (!r_step[0]) begin
                    w_dur = i_cfg.fault_on;
                end else if (w_last_phase) begin
                    w_dur = i_cfg.fault_pause;
                end else begin
                    w_dur = i_cfg.fault_gap;
                end
            end
            default:        w_dur = '0;
        endcase
    end

    assign w_over = (w_elapsed >= {{(TIME_W-DUR_W){1'b0}}, w_dur});

    // Following phase: two-phase modes toggle, fault wraps at its length.
    assign w_two_next   = {{(STEP_W-1){1'b0}}, ~r_step[0]};
    assign w_fault_next = w_last_phase ? '0 : (r_step + 8'd1);

    // State update for one beat.
    always_comb begin
        n_mode   = r_mode;
        n_step   = r_step;
        n_last   = r_last;
        n_led    = r_led;
        n_blinks = r_blinks;
        case (i_item.op)
            OP_SET_MODE: begin
                if ((i_item.mode_code <= MODE_ERROR) && (i_item.mode_code != r_mode)) begin
                    n_mode = i_item.mode_code;
                    n_step = '0;
                    n_last = i_item.now_ms;
                    if (i_item.mode_code == MODE_OFF) begin
                        n_led = 1'b0;
                    end
                end
            end
            OP_SET_BLINKS: begin
                if ((r_mode != MODE_FAULT) || (r_blinks != i_item.blink_count)) begin
                    n_mode   = MODE_FAULT;
                    n_blinks = i_item.blink_count;
                    n_step   = '0;
                    n_last   = i_item.now_ms;
                end
            end
            OP_TICK: begin
                case (r_mode)
                    MODE_HEARTBEAT, MODE_SLOW, MODE_ERROR: begin
                        if (w_over) begin
                            n_last = i_item.now_ms;
                            n_step = w_two_next;
                            n_led  = r_step[0];
                        end
                    end
                    MODE_FAULT: begin
                        if (r_blinks == '0) begin
                            // No blinks configured: hold the LED dark.
                            n_led = 1'b0;
                        end else if (w_over) begin
                            n_last = i_item.now_ms;
                            n_step = w_fault_next;
                            n_led  = ~w_fault_next[0];
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    // Pattern state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_OFF;
            r_step   <= '0;
            r_last   <= '0;
            r_led    <= 1'b0;
            r_blinks <= '0;
        end else if (i_fire) begin
            r_mode   <= n_mode;
            r_step   <= n_step;
            r_last   <= n_last;
            r_led    <= n_led;
            r_blinks <= n_blinks;
        end
    end

    // The result is the state after this beat.
    assign o_res.led_on     = n_led;
    assign o_res.phase_step = n_step;

    `SLBP_ASSERT_IMPL(a_mode_legal, 1'b1, r_mode <= MODE_ERROR)
    `SLBP_ASSERT_IMPL(a_off_is_dark, r_mode == MODE_OFF, !r_led)
    `SLBP_ASSERT_IMPL(a_fault_step_range, (r_mode == MODE_FAULT) && (r_blinks != '0), r_step < w_total)
    `SLBP_ASSERT_IMPL(a_two_phase_step, (r_mode == MODE_HEARTBEAT) || (r_mode == MODE_SLOW) || (r_mode == MODE_ERROR), r_step <= 8'd1)

endmodule

/* verif/tb.sv */
module tb;
    import slbp_pkg::*;

    // Codes that the block must ignore; the package gives them no name.
    localparam logic [OP_W-1:0]   OP_UNUSED    = 2'd3;
    localparam logic [MODE_W-1:0] MODE_UNKNOWN = 3'd7;

    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES   = 200;
    localparam int STALL_LIMIT   = 2000;
    localparam int PHASE_BEATS   = 240;

    // Tracks the LED pattern state and the results still owed by the block.
    class blink_scoreboard;
        logic [DUR_W-1:0]   dur [CFG_N];
        logic [MODE_W-1:0]  mode;
        logic [STEP_W-1:0]  step;
        logic [TIME_W-1:0]  mark_ms;
        logic               led;
        logic [BLINK_W-1:0] blinks;
        t_result            led_expect_q [$];
        int                 errors;
        int                 checked;
        int                 phase_changes;
        logic [STEP_W-1:0]  deepest_step;

        function new();
            foreach (dur[i]) dur[i] = CFG_RESET[i];
            mode          = MODE_OFF;
            step          = '0;
            mark_ms       = '0;
            led           = 1'b0;
            blinks        = '0;
            errors        = 0;
            checked       = 0;
            phase_changes = 0;
            deepest_step  = '0;
        endfunction

        function void set_duration(int idx, logic [DUR_W-1:0] val);
            dur[idx] = val;
        endfunction

        function int pending();
            return led_expect_q.size();
        endfunction

        // Elapsed time uses wrapping 32-bit subtraction.
        function bit phase_done(logic [TIME_W-1:0] now, logic [DUR_W-1:0] span);
            logic [TIME_W-1:0] elapsed;
            elapsed = now - mark_ms;
            return elapsed >= {{(TIME_W-DUR_W){1'b0}}, span};
        endfunction

        // Heartbeat, slow blink and error alternate between two phases.
        function void toggle_phase(logic [TIME_W-1:0] now, logic [DUR_W-1:0] first_ms,
                                   logic [DUR_W-1:0] second_ms);
            if (phase_done(now, (step == '0) ? first_ms : second_ms)) begin
                mark_ms = now;
                step    = (step == '0) ? 8'd1 : 8'd0;
                led     = (step == '0);
                phase_changes++;
            end
        endfunction

        // Fault runs through two phases per blink; the last off phase is the pause.
        function void fault_phase(logic [TIME_W-1:0] now);
            logic [STEP_W-1:0] total;
            logic [DUR_W-1:0]  span;
            total = {blinks, 1'b0};
            if (total == '0) begin
                led = 1'b0;
                return;
            end
            if (!step[0])
                span = dur[CFG_FAULT_ON];
            else if (step == total - 8'd1)
                span = dur[CFG_FAULT_PAUSE];
            else
                span = dur[CFG_FAULT_GAP];
            if (phase_done(now, span)) begin
                mark_ms = now;
                step    = (step + 8'd1 == total) ? 8'd0 : step + 8'd1;
                led     = !step[0];
                phase_changes++;
            end
        endfunction

        // Apply one accepted input beat and queue the result it must produce.
        function void note_beat(t_item it);
            t_result r;
            case (it.op)
                OP_SET_MODE: begin
                    if (it.mode_code <= MODE_ERROR && it.mode_code != mode) begin
                        mode    = it.mode_code;
                        step    = '0;
                        mark_ms = it.now_ms;
                        if (it.mode_code == MODE_OFF)
                            led = 1'b0;
                    end
                end
                OP_SET_BLINKS: begin
                    if (mode != MODE_FAULT || blinks != it.blink_count) begin
                        mode    = MODE_FAULT;
                        blinks  = it.blink_count;
                        step    = '0;
                        mark_ms = it.now_ms;
                    end
                end
                OP_TICK: begin
                    case (mode)
                        MODE_HEARTBEAT: toggle_phase(it.now_ms, dur[CFG_HB_ON], dur[CFG_HB_OFF]);
                        MODE_SLOW: toggle_phase(it.now_ms, dur[CFG_SLOW_ON], dur[CFG_SLOW_OFF]);
                        MODE_FAULT: fault_phase(it.now_ms);
                        MODE_ERROR: begin
                            toggle_phase(it.now_ms, dur[CFG_ERR_PERIOD], dur[CFG_ERR_PERIOD]);
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
            if (step > deepest_step)
                deepest_step = step;
            r.led_on     = led;
            r.phase_step = step;
            led_expect_q.push_back(r);
        endfunction

        // Compare one result beat against the oldest outstanding expectation.
        function void check_beat(t_result got);
            t_result want;
            if (led_expect_q.size() == 0) begin
                errors++;
                $display("%0t unexpected result: expected none, got led_on %0b phase_step %0d",
                         $time, got.led_on, got.phase_step);
                return;
            end
            want = led_expect_q.pop_front();
            checked++;
            if (got.led_on !== want.led_on) begin
                errors++;
                $display("%0t led_on mismatch: expected %0b, got %0b",
                         $time, want.led_on, got.led_on);
            end
            if (got.phase_step !== want.phase_step) begin
                errors++;
                $display("%0t phase_step mismatch: expected %0d, got %0d",
                         $time, want.phase_step, got.phase_step);
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [DUR_W-1:0]   i_cfg_data;

    slbp_in_if  req_if();
    slbp_out_if rsp_if();

    blink_scoreboard sb;
    int              src_idle_pct;
    int              snk_idle_pct;
    int              stride_ms;
    int              accepted_in;
    int              stalled_cycles;
    bit              hold_output_request;
    logic [TIME_W-1:0] stamp_ms;

    status_led_blink_pattern uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if),
        .o_rsp      (rsp_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Observe both channels, score the beats and watch for a hang.
    always @(posedge i_clk) begin
        t_item   taken;
        t_result seen;
        bit      moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready) begin
                taken.op          = req_if.op;
                taken.now_ms      = req_if.now_ms;
                taken.mode_code   = req_if.mode_code;
                taken.blink_count = req_if.blink_count;
                sb.note_beat(taken);
                accepted_in++;
                moved = 1'b1;
            end
            if (rsp_if.valid && rsp_if.ready) begin
                seen.led_on     = rsp_if.led_on;
                seen.phase_step = rsp_if.phase_step;
                sb.check_beat(seen);
                moved = 1'b1;
            end
        end
        stalled_cycles = moved ? 0 : stalled_cycles + 1;
        if (stalled_cycles >= STALL_LIMIT) begin
            $display("%0t no beat moved for %0d cycles", $time, STALL_LIMIT);
            $display("tb: errors");
            $finish;
        end
    end

    // Result side: random back-pressure, plus one long hold-off on request.
    initial begin
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_output_request) begin
                hold_output_request = 1'b0;
                rsp_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            rsp_if.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    function automatic t_item beat(logic [OP_W-1:0] op, logic [TIME_W-1:0] now,
                                   logic [MODE_W-1:0] code, logic [BLINK_W-1:0] count);
        t_item it;
        it.op          = op;
        it.now_ms      = now;
        it.mode_code   = code;
        it.blink_count = count;
        return it;
    endfunction

    // Move the running timestamp: mostly short steps, sometimes jumps or a step back.
    function automatic logic [TIME_W-1:0] advance_stamp();
        int pick;
        pick = $urandom_range(99);
        if (pick < 60)
            stamp_ms += $urandom_range(stride_ms);
        else if (pick < 85)
            stamp_ms += $urandom_range(4 * stride_ms);
        else if (pick < 95)
            stamp_ms += $urandom_range(70000);
        else if (pick < 98)
            stamp_ms = $urandom();
        else
            stamp_ms -= $urandom_range(stride_ms + 1, 1);
        return stamp_ms;
    endfunction

    function automatic t_item noise_beat();
        return beat(OP_W'($urandom_range(3)), advance_stamp(),
                    MODE_W'($urandom_range(7)), BLINK_W'($urandom_range(127)));
    endfunction

    // Present one beat and hold it until the block takes it.
    task automatic offer_beat(input t_item it);
        while ($urandom_range(99) < src_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid       <= 1'b1;
        req_if.op          <= it.op;
        req_if.now_ms      <= it.now_ms;
        req_if.mode_code   <= it.mode_code;
        req_if.blink_count <= it.blink_count;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    // Stop sending and let every outstanding result come back.
    task automatic wait_quiet();
        req_if.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_durations(input logic [DUR_W-1:0] vals [CFG_N]);
        for (int i = 0; i < CFG_N; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= CFG_IDX_W'(i);
            i_cfg_data <= vals[i];
            sb.set_duration(i, vals[i]);
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    // Mostly a mode or blink-count change followed by a run of ticks; the rest is noise.
    task automatic random_phase(input int count);
        int    left;
        t_item it;
        left = count;
        while (left > 0) begin
            if ($urandom_range(99) < 70) begin
                it = noise_beat();
                if ($urandom_range(1)) begin
                    it.op        = OP_SET_MODE;
                    it.mode_code = MODE_W'($urandom_range(MODE_HEARTBEAT, MODE_ERROR));
                end else begin
                    it.op = OP_SET_BLINKS;
                    case ($urandom_range(9))
                        0, 1:    it.blink_count = BLINK_W'($urandom_range(127));
                        2:       it.blink_count = '1;
                        default: it.blink_count = BLINK_W'($urandom_range(4));
                    endcase
                end
                offer_beat(it);
                left--;
                repeat ($urandom_range(40, 5)) begin
                    it    = noise_beat();
                    it.op = OP_TICK;
                    offer_beat(it);
                    left--;
                end
            end else begin
                repeat ($urandom_range(8, 1)) begin
                    offer_beat(noise_beat());
                    left--;
                end
            end
        end
    endtask

    initial begin
        logic [DUR_W-1:0] durs [CFG_N];
        int               budget;
        i_rst_n             <= 1'b0;
        i_cfg_we            <= 1'b0;
        i_cfg_idx           <= CFG_HB_ON;
        i_cfg_data          <= '0;
        req_if.valid        <= 1'b0;
        req_if.op           <= OP_TICK;
        req_if.now_ms       <= '0;
        req_if.mode_code    <= MODE_OFF;
        req_if.blink_count  <= '0;
        hold_output_request = 1'b0;
        accepted_in         = 0;
        stalled_cycles      = 0;
        stamp_ms            = $urandom();
        stride_ms           = 300;
        src_idle_pct        = 33;
        snk_idle_pct        = 60;
        sb = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed beats under the reset durations.
        offer_beat(beat(OP_TICK, 32'd0, MODE_UNKNOWN, 7'd127));
        offer_beat(beat(OP_UNUSED, 32'hFFFF_FFFF, MODE_ERROR, 7'd0));
        offer_beat(beat(OP_SET_MODE, 32'd5, MODE_UNKNOWN, 7'd0));
        offer_beat(beat(OP_SET_MODE, 32'd1000, MODE_HEARTBEAT, 7'd0));
        offer_beat(beat(OP_TICK, 32'd1099, MODE_OFF, 7'd0));
        offer_beat(beat(OP_TICK, 32'd1100, MODE_OFF, 7'd0));
        offer_beat(beat(OP_TICK, 32'd3000, MODE_OFF, 7'd0));
        offer_beat(beat(OP_SET_MODE, 32'd3001, MODE_HEARTBEAT, 7'd0));
        offer_beat(beat(OP_SET_MODE, 32'hFFFF_FF00, MODE_ERROR, 7'd0));
        // Elapsed time across the 32-bit wrap.
        offer_beat(beat(OP_TICK, 32'h0000_0008, MODE_OFF, 7'd0));
        offer_beat(beat(OP_SET_BLINKS, 32'd20, MODE_OFF, 7'd0));
        offer_beat(beat(OP_TICK, 32'd5000, MODE_OFF, 7'd0));
        offer_beat(beat(OP_SET_BLINKS, 32'd5, MODE_OFF, 7'd127));
        offer_beat(beat(OP_TICK, 32'd105, MODE_OFF, 7'd0));
        offer_beat(beat(OP_SET_MODE, 32'd200, MODE_SLOW, 7'd0));
        offer_beat(beat(OP_TICK, 32'd700, MODE_OFF, 7'd0));
        offer_beat(beat(OP_SET_MODE, 32'd800, MODE_OFF, 7'd0));
        offer_beat(beat(OP_TICK, 32'd900000, MODE_OFF, 7'd0));
        // Two blinks through gap, pause and back to the first blink.
        offer_beat(beat(OP_SET_BLINKS, 32'h8000_0000, MODE_OFF, 7'd2));
        offer_beat(beat(OP_TICK, 32'h8000_0064, MODE_OFF, 7'd0));
        offer_beat(beat(OP_TICK, 32'h8000_00FA, MODE_OFF, 7'd0));
        offer_beat(beat(OP_TICK, 32'h8000_015E, MODE_OFF, 7'd0));
        offer_beat(beat(OP_TICK, 32'h8000_073A, MODE_OFF, 7'd0));
        offer_beat(beat(OP_SET_BLINKS, 32'h8000_0800, MODE_OFF, 7'd2));
        offer_beat(beat(OP_SET_MODE, 32'h8000_0900, MODE_FAULT, 7'd0));

        // One random phase per duration setting (two for setting 5).
        for (int setting = 0; setting < 8; setting++) begin
            budget = PHASE_BEATS;
            if (setting == 3) begin
                src_idle_pct = 60;
                snk_idle_pct = 33;
            end else if (setting == 6) begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            if (setting > 0) begin
                wait_quiet();
                foreach (durs[i]) begin
                    case (setting)
                        1: durs[i] = '0;
                        2: durs[i] = '1;
                        3: durs[i] = DUR_W'($urandom_range(12));
                        4: begin
                            case ($urandom_range(4))
                                0:       durs[i] = '0;
                                1:       durs[i] = 16'd1;
                                2:       durs[i] = '1;
                                3:       durs[i] = 16'hFFFE;
                                default: durs[i] = DUR_W'($urandom_range(3000));
                            endcase
                        end
                        5: durs[i] = DUR_W'($urandom_range(200, 1));
                        6: durs[i] = DUR_W'($urandom_range(40));
                        default: durs[i] = CFG_RESET[i];
                    endcase
                end
                load_durations(durs);
            end
            case (setting)
                1: stride_ms = 2;
                2: stride_ms = 20000;
                3: stride_ms = 6;
                4: stride_ms = 800;
                5: stride_ms = 60;
                6: stride_ms = 15;
                default: stride_ms = 300;
            endcase
            if (setting == 0)
                budget = PHASE_BEATS - 25;
            if (setting == 1) begin
                // Zero durations: walk all 254 phases of the largest fault pattern.
                offer_beat(beat(OP_SET_BLINKS, advance_stamp(), MODE_OFF, 7'd127));
                repeat (260) offer_beat(beat(OP_TICK, advance_stamp(), MODE_OFF, 7'd0));
                budget -= 261;
            end
            if (setting == 4)
                hold_output_request = 1'b1;
            if (setting == 5) begin
                random_phase(budget / 2);
                wait_quiet();
                budget -= budget / 2;
            end
            random_phase(budget);
        end

        wait_quiet();
        if (sb.pending() != 0) begin
            $display("%0t %0d expected results never arrived", $time, sb.pending());
            sb.errors++;
        end
        $display("summary: %0d beats accepted, %0d results checked, %0d phase changes",
                 accepted_in, sb.checked, sb.phase_changes);
        $display("summary: max phase %0d; eight duration sets incl. all-zero and all-max, %s",
                 sb.deepest_step, "three idle mixes");
        if (sb.errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end
endmodule
